// File: hdl/etot_pkg.sv
package etot_pkg;

  // width of the input and result fields on the stream ports
  localparam int FIELD_WIDTH = 32;

  // operand selection for the shared divider
  localparam logic [1:0] DIV_N_BY_D   = 2'd0;
  localparam logic [1:0] DIV_ANS_BY_D = 2'd1;
  localparam logic [1:0] DIV_ANS_BY_N = 2'd2;

  // commands from the controller to the datapath
  typedef struct packed {
    logic       load;       // take a new item: n and answer from input, divisor to three
    logic       halve_n;    // n >>= 1
    logic       halve_ans;  // answer -= answer / 2
    logic       div_start;  // start the divider on the selected operands
    logic [1:0] div_sel;    // operand pair for the divider
    logic       n_take_q;   // n = quotient
    logic       ans_sub_q;  // answer -= quotient
    logic       d_step;     // divisor += 2
    logic       res_load;   // move the answer into the output register
  } etot_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic n_zero;
    logic n_even;
    logic n_gt1;
    logic div_busy;
    logic div_done;
    logic d_gt_q;
    logic rem_zero;
    logic out_free;
  } etot_sts_t;

endpackage

// File: hdl/etot_div.sv
module etot_div import etot_pkg::*; #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [VALUE_WIDTH-1:0] dividend,
  input  logic [VALUE_WIDTH-1:0] divisor,
  output logic                   busy,
  output logic                   done,
  output logic [VALUE_WIDTH-1:0] quotient,
  output logic [VALUE_WIDTH-1:0] remainder
);

  localparam int CW = $clog2(VALUE_WIDTH);

  logic [VALUE_WIDTH-1:0] dsr;
  logic [CW-1:0]          count;
  logic [VALUE_WIDTH:0]   shifted;
  logic [VALUE_WIDTH:0]   diff;

  // one restoring step: shift in the next dividend bit and try the subtract
  assign shifted = {remainder, quotient[VALUE_WIDTH-1]};
  assign diff    = shifted - {1'b0, dsr};

  // control: busy for one step per quotient bit, done pulses after the last
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CW'(VALUE_WIDTH - 1);
      end else if (busy) begin
        if (count == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          count <= count - 1'b1;
        end
      end
    end
  end

  // partial remainder and quotient
  always_ff @(posedge clk) begin
    if (start) begin
      dsr       <= divisor;
      quotient  <= dividend;
      remainder <= '0;
    end else if (busy) begin
      if (!diff[VALUE_WIDTH]) begin
        remainder <= diff[VALUE_WIDTH-1:0];
        quotient  <= {quotient[VALUE_WIDTH-2:0], 1'b1};
      end else begin
        remainder <= shifted[VALUE_WIDTH-1:0];
        quotient  <= {quotient[VALUE_WIDTH-2:0], 1'b0};
      end
    end
  end

endmodule

// File: hdl/etot_datapath.sv
module etot_datapath import etot_pkg::*; #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  etot_cmd_t              cmd,
  output etot_sts_t              sts,
  input  logic [FIELD_WIDTH-1:0] n_in,
  output logic [FIELD_WIDTH-1:0] result,
  output logic                   result_valid,
  input  logic                   result_ready
);

  logic [VALUE_WIDTH-1:0] n;
  logic [VALUE_WIDTH-1:0] ans;
  logic [VALUE_WIDTH-1:0] d;
  logic [VALUE_WIDTH-1:0] n_start;
  logic [VALUE_WIDTH-1:0] div_a;
  logic [VALUE_WIDTH-1:0] div_b;
  logic [VALUE_WIDTH-1:0] quotient;
  logic [VALUE_WIDTH-1:0] remainder;
  logic                   div_busy;
  logic                   div_done;

  // input truncated or zero-extended to the working width
  assign n_start = VALUE_WIDTH'(n_in);

  // divider operand selection
  always_comb begin
    case (cmd.div_sel)
      DIV_N_BY_D: begin
        div_a = n;
        div_b = d;
      end
      DIV_ANS_BY_D: begin
        div_a = ans;
        div_b = d;
      end
      DIV_ANS_BY_N: begin
        div_a = ans;
        div_b = n;
      end
      default: begin
        div_a = n;
        div_b = d;
      end
    endcase
  end

  etot_div #(.VALUE_WIDTH(VALUE_WIDTH)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (div_a),
    .divisor   (div_b),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (quotient),
    .remainder (remainder)
  );

  // remaining n
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n <= n_start;
    end else if (cmd.halve_n) begin
      n <= n >> 1;
    end else if (cmd.n_take_q) begin
      n <= quotient;
    end
  end

  // running answer
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ans <= n_start;
    end else if (cmd.halve_ans) begin
      ans <= ans - (ans >> 1);
    end else if (cmd.ans_sub_q) begin
      ans <= ans - quotient;
    end
  end

  // odd trial divisor
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      d <= VALUE_WIDTH'(3);
    end else if (cmd.d_step) begin
      d <= d + VALUE_WIDTH'(2);
    end
  end

  // output register, freed as the receiver takes the item
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.res_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      result <= FIELD_WIDTH'(ans);
    end
  end

  // status flags
  always_comb begin
    sts.n_zero   = (n == '0);
    sts.n_even   = !n[0];
    sts.n_gt1    = (n > VALUE_WIDTH'(1));
    sts.div_busy = div_busy;
    sts.div_done = div_done;
    sts.d_gt_q   = (d > quotient);
    sts.rem_zero = (remainder == '0);
    sts.out_free = !result_valid || result_ready;
  end

endmodule

// File: hdl/etot_ctrl.sv
module etot_ctrl import etot_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  etot_sts_t sts,
  output etot_cmd_t cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CHK    = 4'd1;
  localparam logic [3:0] S_STRIP2 = 4'd2;
  localparam logic [3:0] S_TSTART = 4'd3;
  localparam logic [3:0] S_TEST   = 4'd4;
  localparam logic [3:0] S_SSTART = 4'd5;
  localparam logic [3:0] S_STRIP  = 4'd6;
  localparam logic [3:0] S_ASUB   = 4'd7;
  localparam logic [3:0] S_LAST   = 4'd8;
  localparam logic [3:0] S_LSUB   = 4'd9;
  localparam logic [3:0] S_FIN    = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.div_sel = DIV_N_BY_D;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHK;
        end
      end
      // zero gives zero; an even n loses half the answer once
      S_CHK: begin
        if (sts.n_zero) begin
          state_next = S_FIN;
        end else if (sts.n_even) begin
          cmd.halve_ans = 1'b1;
          state_next    = S_STRIP2;
        end else begin
          state_next = S_TSTART;
        end
      end
      // shift out every factor two
      S_STRIP2: begin
        if (sts.n_even) begin
          cmd.halve_n = 1'b1;
        end else begin
          state_next = S_TSTART;
        end
      end
      S_TSTART: begin
        cmd.div_start = 1'b1;
        state_next    = S_TEST;
      end
      // bound check and divisibility from one division n / d
      S_TEST: begin
        if (sts.div_done) begin
          if (sts.d_gt_q) begin
            state_next = S_LAST;
          end else if (sts.rem_zero) begin
            cmd.n_take_q = 1'b1;
            state_next   = S_SSTART;
          end else begin
            cmd.d_step = 1'b1;
            state_next = S_TSTART;
          end
        end
      end
      S_SSTART: begin
        cmd.div_start = 1'b1;
        state_next    = S_STRIP;
      end
      // divide out further powers, then answer -= answer / d
      S_STRIP: begin
        if (sts.div_done) begin
          if (sts.rem_zero) begin
            cmd.n_take_q = 1'b1;
            state_next   = S_SSTART;
          end else begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_ANS_BY_D;
            state_next    = S_ASUB;
          end
        end
      end
      S_ASUB: begin
        if (sts.div_done) begin
          cmd.ans_sub_q = 1'b1;
          cmd.d_step    = 1'b1;
          state_next    = S_TSTART;
        end
      end
      // leftover prime factor
      S_LAST: begin
        if (sts.n_gt1) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_ANS_BY_N;
          state_next    = S_LSUB;
        end else begin
          state_next = S_FIN;
        end
      end
      S_LSUB: begin
        if (sts.div_done) begin
          cmd.ans_sub_q = 1'b1;
          state_next    = S_FIN;
        end
      end
      // hand the answer to the output register once it is free
      S_FIN: begin
        if (sts.out_free) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: hdl/euler_totient_trial_division.sv
// Euler totient by trial division.
// Input channel s_axis carries one unsigned number per item; output channel
// m_axis carries its totient, one result item per input item, in order.
// Input 0 gives 0 and input 1 gives 1.
// One item is worked on at a time: s_axis_tready is high only while the
// controller is idle. The factor two is stripped one trailing zero bit at a
// time; each odd trial divisor takes one division n / d, and a divisor that
// divides n takes further divisions until it no longer divides, plus one
// for the answer; all trial divisions go through one shared restoring
// divider that makes one quotient bit per cycle.
// Trial divisors run up to the square root of what is left of n, so a
// 32-bit prime tries about 32768 odd trial divisors.
// The result waits in an output register; the next item is accepted while
// it waits, and only the hand-over of a finished answer stalls until the
// receiver has taken the previous one.
// Reset is synchronous: the controller returns to idle and the output
// register is emptied. There is no stored state to clear.
module euler_totient_trial_division import etot_pkg::*; #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [FIELD_WIDTH-1:0] s_axis_tdata,   // [31:0] n_value
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [FIELD_WIDTH-1:0] m_axis_tdata    // [31:0] totient
);

  etot_cmd_t cmd;
  etot_sts_t sts;

  etot_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  etot_datapath #(.VALUE_WIDTH(VALUE_WIDTH)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .n_in         (s_axis_tdata),
    .result       (m_axis_tdata),
    .result_valid (m_axis_tvalid),
    .result_ready (m_axis_tready)
  );

  // a new item is never taken on the cycle right after one was accepted
  assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted twice in a row");

  // the divider is only started when it is free
  assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !sts.div_busy)
    else $error("divider restarted while busy");

  // an answer never overwrites a result the receiver has not taken
  assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result overwritten before it was taken");

endmodule
